### src/idea_pkg.sv
// ----------------------------------------------------------------------------
// IDEA cipher package
// Shared widths, register indexes, datapath operation codes and the
// command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package idea_pkg;

  localparam int ROUNDS_DEFAULT = 8;
  localparam int WORD_W         = 16;
  localparam int BLOCK_W        = 64;
  localparam int KEY_IDX_W      = 6;
  localparam int MEM_AW         = KEY_IDX_W + 1;
  localparam int ROUND_W        = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int NKEYS          = 52;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_IN,
    OP_RED_ADD,
    OP_MUL_T0,
    OP_RED_T0,
    OP_MUL_T1,
    OP_FINISH,
    OP_OUT_FIN,
    OP_OUT_LOAD,
    OP_KS_INIT,
    OP_KS_ENC,
    OP_DEC_NEG,
    OP_DEC_COPY,
    OP_INV_LOAD,
    OP_INV_SQ,
    OP_INV_MA,
    OP_INV_LATCH,
    OP_INV_WR
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              cfg_we;
    logic              rot_long;
    logic [MEM_AW-1:0] rd_addr_a;
    logic [MEM_AW-1:0] rd_addr_b;
    logic [MEM_AW-1:0] wr_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic decrypt_mode;
  } dp_status_t;

endpackage

### src/idea_mulmod.sv
// ----------------------------------------------------------------------------
// IDEA modular multiplier
// Multiplies modulo 65537 with zero standing for 65536. The raw product is
// registered; the reduction follows the register.
// ----------------------------------------------------------------------------
module idea_mulmod (
  input  logic                          clk,
  input  logic [idea_pkg::WORD_W-1:0]   a,
  input  logic [idea_pkg::WORD_W-1:0]   b,
  output logic [idea_pkg::WORD_W-1:0]   product
);

  logic [idea_pkg::WORD_W-1:0]   a_q;
  logic [idea_pkg::WORD_W-1:0]   b_q;
  logic [2*idea_pkg::WORD_W-1:0] prod_q;
  logic [idea_pkg::WORD_W-1:0]   lo;
  logic [idea_pkg::WORD_W-1:0]   hi;
  logic [idea_pkg::WORD_W-1:0]   diff;

  always_ff @(posedge clk) begin
    a_q    <= a;
    b_q    <= b;
    prod_q <= {{idea_pkg::WORD_W{1'b0}}, a} * {{idea_pkg::WORD_W{1'b0}}, b};
  end

  assign lo   = prod_q[idea_pkg::WORD_W-1:0];
  assign hi   = prod_q[2*idea_pkg::WORD_W-1:idea_pkg::WORD_W];
  assign diff = lo - hi;

  // A zero operand means 65536, which is -1 modulo 65537.
  always_comb begin
    priority if (a_q == '0) begin
      product = 16'd1 - b_q;
    end else if (b_q == '0) begin
      product = 16'd1 - a_q;
    end else begin
      product = diff + {{(idea_pkg::WORD_W-1){1'b0}}, (lo < hi)};
    end
  end

endmodule

### src/idea_datapath.sv
// ----------------------------------------------------------------------------
// IDEA datapath
// Key registers, subkey memory, block word registers and two modular
// multipliers (one shared), driven one operation per cycle by the controller.
// ----------------------------------------------------------------------------
module idea_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  idea_pkg::dp_cmd_t                 cmd,
  output idea_pkg::dp_status_t              status,
  input  logic [idea_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [idea_pkg::BLOCK_W-1:0]      cfg_data,
  input  logic [idea_pkg::BLOCK_W-1:0]      data_block,
  output logic [idea_pkg::BLOCK_W-1:0]      result_block
);

  localparam int W     = idea_pkg::WORD_W;
  localparam int DEPTH = 2 ** idea_pkg::MEM_AW;

  logic [idea_pkg::BLOCK_W-1:0]   key_high;
  logic [idea_pkg::BLOCK_W-1:0]   key_low;
  logic                           mode;
  logic [2*idea_pkg::BLOCK_W-1:0] kreg;
  logic [W-1:0] x1, x2, x3, x4, t0, acc, ia;
  logic [idea_pkg::BLOCK_W-1:0]   result_q;

  // Encryption subkeys in the lower half, decryption subkeys in the upper.
  logic [W-1:0] mem [0:DEPTH-1];
  logic [W-1:0] rd_a;
  logic [W-1:0] rd_b;
  logic         we;
  logic [W-1:0] wdata;

  logic [W-1:0] mul_a_x, mul_a_y, mul_b_x, mul_b_y;
  logic [W-1:0] red_a, red_b;
  logic [W-1:0] t1, t2;

  idea_mulmod u_mul_a (.clk(clk), .a(mul_a_x), .b(mul_a_y), .product(red_a));
  idea_mulmod u_mul_b (.clk(clk), .a(mul_b_x), .b(mul_b_y), .product(red_b));

  assign t1 = red_a;
  assign t2 = t0 + t1;

  always_comb begin
    mul_a_x = '0;
    mul_a_y = '0;
    mul_b_x = '0;
    mul_b_y = '0;
    case (cmd.op)
      idea_pkg::OP_MUL_IN: begin
        mul_a_x = x1;
        mul_a_y = rd_a;
        mul_b_x = x4;
        mul_b_y = rd_b;
      end
      idea_pkg::OP_MUL_T0: begin
        mul_a_x = x1 ^ x3;
        mul_a_y = rd_a;
      end
      idea_pkg::OP_MUL_T1: begin
        mul_a_x = t0 + (x2 ^ x4);
        mul_a_y = rd_a;
      end
      idea_pkg::OP_INV_SQ: begin
        mul_a_x = acc;
        mul_a_y = acc;
      end
      idea_pkg::OP_INV_MA: begin
        mul_a_x = acc;
        mul_a_y = ia;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    wdata = rd_a;
    case (cmd.op)
      idea_pkg::OP_KS_ENC: begin
        we    = 1'b1;
        wdata = kreg[2*idea_pkg::BLOCK_W-1 -: W];
      end
      idea_pkg::OP_DEC_NEG: begin
        we    = 1'b1;
        wdata = {W{1'b0}} - rd_a;
      end
      idea_pkg::OP_DEC_COPY: begin
        we    = 1'b1;
        wdata = rd_a;
      end
      idea_pkg::OP_INV_WR: begin
        we    = 1'b1;
        wdata = acc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[cmd.wr_addr] <= wdata;
    end
    rd_a <= mem[cmd.rd_addr_a];
    rd_b <= mem[cmd.rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      mode     <= 1'b0;
    end else if (cmd.cfg_we) begin
      unique case (cfg_index)
        idea_pkg::REG_KEY_HIGH:     key_high <= cfg_data;
        idea_pkg::REG_KEY_LOW:      key_low  <= cfg_data;
        idea_pkg::REG_DECRYPT_MODE: mode     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      idea_pkg::OP_LOAD: begin
        {x1, x2, x3, x4} <= data_block;
      end
      idea_pkg::OP_RED_ADD: begin
        x1 <= red_a;
        x2 <= x2 + rd_a;
        x3 <= x3 + rd_b;
        x4 <= red_b;
      end
      idea_pkg::OP_RED_T0: begin
        t0 <= red_a;
      end
      idea_pkg::OP_FINISH: begin
        x1 <= x1 ^ t1;
        x2 <= x3 ^ t1;
        x3 <= x2 ^ t2;
        x4 <= x4 ^ t2;
      end
      idea_pkg::OP_OUT_FIN: begin
        // The output transform undoes the middle swap of the last round.
        x1 <= red_a;
        x2 <= x3 + rd_a;
        x3 <= x2 + rd_b;
        x4 <= red_b;
      end
      idea_pkg::OP_OUT_LOAD: begin
        result_q <= {x1, x2, x3, x4};
      end
      idea_pkg::OP_KS_INIT: begin
        kreg <= {key_high, key_low};
      end
      idea_pkg::OP_KS_ENC: begin
        // After the eighth word the key has turned a full circle, so the
        // extra 25-bit rotation is folded into that step.
        if (cmd.rot_long) begin
          kreg <= {kreg[86:0], kreg[127:87]};
        end else begin
          kreg <= {kreg[111:0], kreg[127:112]};
        end
      end
      idea_pkg::OP_INV_LOAD: begin
        acc <= rd_a;
        ia  <= rd_a;
      end
      idea_pkg::OP_INV_LATCH: begin
        acc <= red_a;
      end
      default: begin
      end
    endcase
  end

  assign status.decrypt_mode = mode;
  assign result_block        = result_q;

endmodule

### src/idea_ctrl.sv
// ----------------------------------------------------------------------------
// IDEA controller
// Sequences the subkey schedule, the rounds of each item and the handshakes,
// and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module idea_ctrl #(
  parameter int ROUNDS = idea_pkg::ROUNDS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  output logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [idea_pkg::CFG_IDX_W-1:0] cfg_index,
  output idea_pkg::dp_cmd_t              cmd,
  input  idea_pkg::dp_status_t           status
);

  localparam int KW = idea_pkg::KEY_IDX_W;
  localparam logic [idea_pkg::ROUND_W-1:0] LAST_ROUND = idea_pkg::ROUND_W'(ROUNDS);
  localparam logic [KW-1:0] LAST_BASE = KW'(6 * ROUNDS);
  localparam logic [KW-1:0] LAST_KEY  = KW'(idea_pkg::NKEYS - 1);
  localparam logic [3:0]    INV_STEPS = 4'd14;

  localparam logic [4:0] S_KS_INIT = 5'd0;
  localparam logic [4:0] S_KS_ENC  = 5'd1;
  localparam logic [4:0] S_KD_RD   = 5'd2;
  localparam logic [4:0] S_KD_OP   = 5'd3;
  localparam logic [4:0] S_KI_SQ   = 5'd4;
  localparam logic [4:0] S_KI_SQL  = 5'd5;
  localparam logic [4:0] S_KI_MA   = 5'd6;
  localparam logic [4:0] S_KI_MAL  = 5'd7;
  localparam logic [4:0] S_KI_WR   = 5'd8;
  localparam logic [4:0] S_IDLE    = 5'd9;
  localparam logic [4:0] S_P0      = 5'd10;
  localparam logic [4:0] S_P1      = 5'd11;
  localparam logic [4:0] S_P2      = 5'd12;
  localparam logic [4:0] S_P3      = 5'd13;
  localparam logic [4:0] S_P4      = 5'd14;
  localparam logic [4:0] S_P5      = 5'd15;
  localparam logic [4:0] S_OF      = 5'd16;
  localparam logic [4:0] S_DONE    = 5'd17;

  logic [4:0]                   state, state_next;
  logic [idea_pkg::ROUND_W-1:0] rnd, rnd_next;
  logic [KW-1:0]                base, base_next;
  logic [KW-1:0]                sbase, sbase_next;
  logic [KW-1:0]                idx, idx_next;
  logic [2:0]                   w, w_next;
  logic [3:0]                   cnt, cnt_next;
  logic                         out_valid_next;
  logic                         advance;
  logic                         edge_round;
  logic [KW-1:0]                src;
  logic                         mode;

  assign mode       = status.decrypt_mode;
  assign edge_round = (rnd == '0) || (rnd == LAST_ROUND);
  assign cfg_ready  = (state == S_IDLE);
  assign in_stall   = (state != S_IDLE) || cfg_valid;

  // Source entry of the encryption table for decryption entry (rnd, w).
  always_comb begin
    unique case (w)
      3'd0:    src = sbase;
      3'd1:    src = edge_round ? sbase + 6'd1 : sbase + 6'd2;
      3'd2:    src = edge_round ? sbase + 6'd2 : sbase + 6'd1;
      3'd3:    src = sbase + 6'd3;
      3'd4:    src = sbase - 6'd2;
      3'd5:    src = sbase - 6'd1;
      default: src = sbase;
    endcase
  end

  always_comb begin
    state_next     = state;
    rnd_next       = rnd;
    base_next      = base;
    sbase_next     = sbase;
    idx_next       = idx;
    w_next         = w;
    cnt_next       = cnt;
    out_valid_next = out_valid && out_stall;
    advance        = 1'b0;

    cmd           = '0;
    cmd.op        = idea_pkg::OP_NONE;
    cmd.rd_addr_a = {mode, 6'd0};
    cmd.rd_addr_b = {mode, 6'd3};
    cmd.wr_addr   = {1'b1, base + {3'b000, w}};

    unique case (state)
      S_KS_INIT: begin
        cmd.op     = idea_pkg::OP_KS_INIT;
        idx_next   = '0;
        state_next = S_KS_ENC;
      end
      S_KS_ENC: begin
        cmd.op       = idea_pkg::OP_KS_ENC;
        cmd.wr_addr  = {1'b0, idx};
        cmd.rot_long = (idx[2:0] == 3'd7);
        if (idx == LAST_KEY) begin
          rnd_next   = '0;
          base_next  = '0;
          w_next     = '0;
          sbase_next = LAST_BASE;
          state_next = S_KD_RD;
        end else begin
          idx_next = idx + 6'd1;
        end
      end
      S_KD_RD: begin
        cmd.rd_addr_a = {1'b0, src};
        state_next    = S_KD_OP;
      end
      S_KD_OP: begin
        if (w == 3'd0 || w == 3'd3) begin
          cmd.op     = idea_pkg::OP_INV_LOAD;
          cnt_next   = '0;
          state_next = S_KI_SQ;
        end else begin
          cmd.op  = (w == 3'd1 || w == 3'd2) ? idea_pkg::OP_DEC_NEG : idea_pkg::OP_DEC_COPY;
          advance = 1'b1;
        end
      end
      // The inverse is x to the power 65535, built by square and multiply.
      S_KI_SQ: begin
        cmd.op     = idea_pkg::OP_INV_SQ;
        state_next = S_KI_SQL;
      end
      S_KI_SQL: begin
        cmd.op     = idea_pkg::OP_INV_LATCH;
        state_next = S_KI_MA;
      end
      S_KI_MA: begin
        cmd.op     = idea_pkg::OP_INV_MA;
        state_next = S_KI_MAL;
      end
      S_KI_MAL: begin
        cmd.op = idea_pkg::OP_INV_LATCH;
        if (cnt == INV_STEPS) begin
          state_next = S_KI_WR;
        end else begin
          cnt_next   = cnt + 4'd1;
          state_next = S_KI_SQ;
        end
      end
      S_KI_WR: begin
        cmd.op  = idea_pkg::OP_INV_WR;
        advance = 1'b1;
      end
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_we = 1'b1;
          if (cfg_index == idea_pkg::REG_KEY_HIGH || cfg_index == idea_pkg::REG_KEY_LOW) begin
            state_next = S_KS_INIT;
          end
        end else if (in_valid) begin
          cmd.op     = idea_pkg::OP_LOAD;
          rnd_next   = '0;
          base_next  = '0;
          state_next = S_P0;
        end
      end
      // Phases P0, P1, P3 and P5 fetch the subkeys that the following phase uses.
      S_P0: begin
        cmd.op        = idea_pkg::OP_MUL_IN;
        cmd.rd_addr_a = {mode, base + 6'd1};
        cmd.rd_addr_b = {mode, base + 6'd2};
        state_next    = (rnd == LAST_ROUND) ? S_OF : S_P1;
      end
      S_P1: begin
        cmd.op        = idea_pkg::OP_RED_ADD;
        cmd.rd_addr_a = {mode, base + 6'd4};
        state_next    = S_P2;
      end
      S_P2: begin
        cmd.op     = idea_pkg::OP_MUL_T0;
        state_next = S_P3;
      end
      S_P3: begin
        cmd.op        = idea_pkg::OP_RED_T0;
        cmd.rd_addr_a = {mode, base + 6'd5};
        state_next    = S_P4;
      end
      S_P4: begin
        cmd.op     = idea_pkg::OP_MUL_T1;
        state_next = S_P5;
      end
      S_P5: begin
        cmd.op        = idea_pkg::OP_FINISH;
        cmd.rd_addr_a = {mode, base + 6'd6};
        cmd.rd_addr_b = {mode, base + 6'd9};
        base_next     = base + 6'd6;
        rnd_next      = rnd + 4'd1;
        state_next    = S_P0;
      end
      S_OF: begin
        cmd.op     = idea_pkg::OP_OUT_FIN;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.op         = idea_pkg::OP_OUT_LOAD;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Step to the next decryption entry; the last round has no entries 4, 5.
    if (advance) begin
      if (rnd == LAST_ROUND && w == 3'd3) begin
        state_next = S_IDLE;
      end else if (w == 3'd5) begin
        w_next     = '0;
        rnd_next   = rnd + 4'd1;
        base_next  = base + 6'd6;
        sbase_next = sbase - 6'd6;
        state_next = S_KD_RD;
      end else begin
        w_next     = w + 3'd1;
        state_next = S_KD_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_KS_INIT;
      out_valid <= 1'b0;
      rnd       <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      rnd       <= rnd_next;
    end
  end

  always_ff @(posedge clk) begin
    base  <= base_next;
    sbase <= sbase_next;
    idx   <= idx_next;
    w     <= w_next;
    cnt   <= cnt_next;
  end

  a_no_item_with_cfg: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> cfg_ready)
    else $error("item accepted outside the idle state");

  a_key_write_rebuilds: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready &&
     (cfg_index == idea_pkg::REG_KEY_HIGH || cfg_index == idea_pkg::REG_KEY_LOW))
    |=> (state == S_KS_INIT))
    else $error("key write did not restart the subkey schedule");

  a_out_transform_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_OF) |=> (state == S_DONE))
    else $error("output transform not followed by result hand-off");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && out_stall) |=> (state == S_DONE && out_valid))
    else $error("finished item dropped while the output was stalled");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (rnd <= LAST_ROUND))
    else $error("round counter out of range");

endmodule

### src/idea_block_cipher.sv
// ----------------------------------------------------------------------------
// IDEA block cipher
// 64-bit block, 128-bit key, ECB, with encryption and decryption subkeys
// built in hardware after every key write.
// ----------------------------------------------------------------------------
// After reset, and after every write of key_high or key_low, the block builds
// both subkey tables before it takes an item. Most of that work is in the
// inverse unit, which raises each multiplication subkey to the power 65535
// by square and multiply through one shared modular multiplier. During that
// time in_stall is high and cfg_ready is low. Each round of an item runs in
// six steps because its three dependent modular multiplications each need a
// product register and a reduction step. A finished result waits in the
// output register while the next item is accepted.
module idea_block_cipher #(
  parameter int ROUNDS = idea_pkg::ROUNDS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [idea_pkg::BLOCK_W-1:0]   data_block,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [idea_pkg::BLOCK_W-1:0]   result_block,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [idea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [idea_pkg::BLOCK_W-1:0]   cfg_data
);

  idea_pkg::dp_cmd_t    cmd;
  idea_pkg::dp_status_t status;

  idea_ctrl #(
    .ROUNDS(ROUNDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cmd       (cmd),
    .status    (status)
  );

  idea_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_block   (data_block),
    .result_block (result_block)
  );

endmodule

### tb/idea_checker.sv
// ----------------------------------------------------------------------------
// IDEA cipher checker
// Watches the key, input and output channels of the cipher. It keeps its own
// key, subkey tables and mode, and computes each expected result block when
// an item is accepted. Result blocks are compared in order, and failures are
// counted for the testbench top.
// ----------------------------------------------------------------------------
module idea_checker #(
  parameter int ROUNDS = idea_pkg::ROUNDS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [idea_pkg::BLOCK_W-1:0]   data_block,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [idea_pkg::BLOCK_W-1:0]   result_block,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [idea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [idea_pkg::BLOCK_W-1:0]   cfg_data,
  output int                             fail_count,
  output int                             pending
);

  logic [63:0] key_hi, key_lo;
  logic        decrypt_sel;
  logic [15:0] enc_keys [idea_pkg::NKEYS];
  logic [15:0] dec_keys [idea_pkg::NKEYS];
  logic [63:0] expected_blocks [$];

  function automatic logic [15:0] mul_mod(input logic [15:0] a, input logic [15:0] b);
    logic [33:0] x, y;
    x = (a == 16'd0) ? 34'h10000 : {18'd0, a};
    y = (b == 16'd0) ? 34'h10000 : {18'd0, b};
    return 16'((x * y) % 34'd65537);
  endfunction

  // Inverse by raising to the power 65535; zero (65536) maps to itself.
  function automatic logic [15:0] inv_mod(input logic [15:0] a);
    logic [63:0] base, acc;
    int          e;
    base = (a == 16'd0) ? 64'h10000 : {48'd0, a};
    acc  = 64'd1;
    e    = 65535;
    while (e != 0) begin
      if (e & 1) acc = (acc * base) % 64'd65537;
      base = (base * base) % 64'd65537;
      e = e >> 1;
    end
    return acc[15:0];
  endfunction

  task automatic build_subkeys();
    logic [127:0] k;
    int           w, j;
    k = {key_hi, key_lo};
    for (int i = 0; i < idea_pkg::NKEYS; i++) begin
      w = i % 8;
      if (i > 0 && w == 0) k = {k[102:0], k[127:103]};
      enc_keys[i] = k[127 - 16*w -: 16];
    end
    for (int i = 0; i < idea_pkg::NKEYS; i++) dec_keys[i] = 16'd0;
    for (int r = 0; r <= ROUNDS; r++) begin
      j = ROUNDS - r;
      dec_keys[6*r] = inv_mod(enc_keys[6*j]);
      if (r == 0 || r == ROUNDS) begin
        dec_keys[6*r+1] = -enc_keys[6*j+1];
        dec_keys[6*r+2] = -enc_keys[6*j+2];
      end else begin
        dec_keys[6*r+1] = -enc_keys[6*j+2];
        dec_keys[6*r+2] = -enc_keys[6*j+1];
      end
      dec_keys[6*r+3] = inv_mod(enc_keys[6*j+3]);
      if (r < ROUNDS) begin
        dec_keys[6*r+4] = enc_keys[6*(j-1)+4];
        dec_keys[6*r+5] = enc_keys[6*(j-1)+5];
      end
    end
  endtask

  function automatic logic [63:0] cipher_block(input logic [63:0] blk);
    logic [15:0] k [idea_pkg::NKEYS];
    logic [15:0] x1, x2, x3, x4, t0, t1, t2, a;
    int          b;
    if (decrypt_sel) begin
      k = dec_keys;
    end else begin
      k = enc_keys;
    end
    x1 = blk[63:48];
    x2 = blk[47:32];
    x3 = blk[31:16];
    x4 = blk[15:0];
    for (int r = 0; r < ROUNDS; r++) begin
      b  = 6 * r;
      x1 = mul_mod(x1, k[b]);
      x2 = x2 + k[b+1];
      x3 = x3 + k[b+2];
      x4 = mul_mod(x4, k[b+3]);
      t0 = mul_mod(x1 ^ x3, k[b+4]);
      t1 = mul_mod(t0 + (x2 ^ x4), k[b+5]);
      t2 = t0 + t1;
      x1 = x1 ^ t1;
      x4 = x4 ^ t2;
      a  = x2 ^ t2;
      x2 = x3 ^ t1;
      x3 = a;
    end
    b = 6 * ROUNDS;
    return {mul_mod(x1, k[b]), 16'(x3 + k[b+1]), 16'(x2 + k[b+2]), mul_mod(x4, k[b+3])};
  endfunction

  assign pending = expected_blocks.size();

  always @(posedge clk) begin
    logic [63:0] want;
    if (rst) begin
      key_hi      = 64'd0;
      key_lo      = 64'd0;
      decrypt_sel = 1'b0;
      build_subkeys();
      expected_blocks.delete();
      fail_count  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          fail_count++;
          $display("%0t: result %h arrived with no item outstanding", $time, result_block);
        end else begin
          want = expected_blocks.pop_front();
          if (result_block !== want) begin
            fail_count++;
            $display("%0t: result_block expected %h actual %h", $time, want, result_block);
          end
        end
      end
      if (in_valid && !in_stall) expected_blocks.push_back(cipher_block(data_block));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          idea_pkg::REG_KEY_HIGH: begin
            key_hi = cfg_data;
            build_subkeys();
          end
          idea_pkg::REG_KEY_LOW: begin
            key_lo = cfg_data;
            build_subkeys();
          end
          idea_pkg::REG_DECRYPT_MODE: decrypt_sel = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// IDEA cipher testbench
// Drives keys, modes and data blocks into the cipher with random idle
// cycles on both channels, including a long output hold-off and a drain
// pause. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [idea_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 80;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [idea_pkg::BLOCK_W-1:0]   data_block = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [idea_pkg::BLOCK_W-1:0]   result_block;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [idea_pkg::CFG_IDX_W-1:0] cfg_index = idea_pkg::REG_KEY_HIGH;
  logic [idea_pkg::BLOCK_W-1:0]   cfg_data = '0;

  int fail_count, pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int cycles = 0;
  int blocks_sent = 0;
  int key_writes = 0;

  idea_block_cipher dut (.*);

  idea_checker chk (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output side: random stalls, or a long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      out_stall <= (!rst && $urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_block(input logic [63:0] blk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_block <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    blocks_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [idea_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == idea_pkg::REG_KEY_HIGH || idx == idea_pkg::REG_KEY_LOW) key_writes++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Keys lean toward the extremes now and then.
  function automatic logic [63:0] rand_key();
    case ($urandom_range(5))
      0: return 64'd0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  // Data blocks often carry all-ones words, or zero words to hit the 65536 operand.
  function automatic logic [63:0] rand_block();
    logic [63:0] b;
    b = rand64();
    for (int w = 0; w < 4; w++) begin
      case ($urandom_range(7))
        0: b[16*w +: 16] = 16'h0000;
        1: b[16*w +: 16] = 16'hffff;
        default: ;
      endcase
    end
    return b;
  endfunction

  initial begin
    logic [63:0] directed [8];
    int          phase_items;

    directed = '{64'h0, '1, 64'h0000_0001_0002_0003, 64'h8000_0000_0000_0001,
                 64'haaaa_5555_aaaa_5555, 64'hffff_0000_ffff_0000,
                 64'h0000_ffff_0000_ffff, 64'h0001_0001_0001_0001};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Blocks before any key write use the all-zero reset key.
    foreach (directed[i]) send_block(directed[i]);
    drain();

    // Well-known key 0001..0008; then decrypt, then an ignored register index.
    write_reg(idea_pkg::REG_KEY_HIGH, 64'h0001_0002_0003_0004);
    write_reg(idea_pkg::REG_KEY_LOW, 64'h0005_0006_0007_0008);
    foreach (directed[i]) send_block(directed[i]);
    drain();
    write_reg(idea_pkg::REG_DECRYPT_MODE, 64'hffff_ffff_ffff_fffe);
    write_reg(idea_pkg::REG_DECRYPT_MODE, 64'h1);
    send_block(64'h11fb_ed2b_0198_6de5);
    send_block(rand_block());
    drain();
    write_reg(REG_UNUSED, '1);
    write_reg(idea_pkg::REG_KEY_HIGH, '1);
    write_reg(idea_pkg::REG_KEY_LOW, '1);
    send_block(64'h0);
    send_block('1);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      if (phase < 4) begin
        tx_idle_pct = 38;
        rx_idle_pct = 61;
      end else if (phase < 8) begin
        tx_idle_pct = 61;
        rx_idle_pct = 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if ($urandom_range(2) != 0) write_reg(idea_pkg::REG_KEY_HIGH, rand_key());
      if ($urandom_range(2) != 0) write_reg(idea_pkg::REG_KEY_LOW, rand_key());
      write_reg(idea_pkg::REG_DECRYPT_MODE, rand64());
      phase_items = $urandom_range(25, 40);
      for (int n = 0; n < phase_items; n++) begin
        if (phase == 9 && n == 2) hold_req = 1'b1;
        if (phase == 5 && n == 15) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_block(rand_block());
      end
      drain();
    end

    drain();
    $display("Sent %0d blocks under %0d key writes, both modes, with random and long stalls.",
             blocks_sent, key_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures, %0d results missing", fail_count, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
src/idea_pkg.sv
src/idea_mulmod.sv
src/idea_datapath.sv
src/idea_ctrl.sv
src/idea_block_cipher.sv
tb/idea_checker.sv
tb/testbench.sv
